@@ sv/rsi_pkg.sv @@
package rsi_pkg;

  localparam int LIMB_W     = 32;
  localparam int MAC_NL     = 3;
  localparam int OP_W       = MAC_NL * LIMB_W;
  localparam int PP_W       = 2 * OP_W;
  localparam int A_W        = 64;
  localparam int B_W        = 67;
  localparam int C_W        = 67;
  localparam int MAG_W      = 66;
  localparam int DL_W       = 134;
  localparam int ROOT_W     = DL_W / 2;
  localparam int T_W        = 69;
  localparam int TMAG_W     = T_W - 1;
  localparam int DEN_W      = A_W + 1;
  localparam int QUO_W      = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_X = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_Y = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_Z = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS   = 4'd3;

  localparam logic [QUO_W-1:0] DIST_MIN = 32'h8000_0000;
  localparam logic [QUO_W-1:0] DIST_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
  } in_req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] distance;
    logic               degenerate;
  } out_res_t;

  typedef struct packed {
    logic signed [B_W-1:0] b;
    logic [A_W-1:0]        a;
    logic                  degen;
  } mac_side_t;

  typedef struct packed {
    logic signed [B_W-1:0] b;
    logic [A_W-1:0]        a;
    logic                  dneg;
    logic                  degen;
  } sq_side_t;

  typedef struct packed {
    logic ovf;
    logic nneg;
    logic dneg;
    logic degen;
  } div_flags_t;

endpackage

@@ sv/rsi_mac_cell.sv @@
module rsi_mac_cell import rsi_pkg::*; #(
  parameter int I  = 0,
  parameter int J  = 0,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            en,
  input  logic [OP_W-1:0] x_in,
  input  logic [OP_W-1:0] y_in,
  input  logic [PP_W-1:0] acc_in,
  input  logic [SW-1:0]   side_in,
  output logic [OP_W-1:0] x_out,
  output logic [OP_W-1:0] y_out,
  output logic [PP_W-1:0] acc_out,
  output logic [SW-1:0]   side_out
);

  logic [2*LIMB_W-1:0] pp;
  logic [PP_W-1:0]     acc_nxt;
  logic [OP_W-1:0]     x_r, y_r;
  logic [PP_W-1:0]     acc_r;
  logic [SW-1:0]       side_r;

  assign pp      = (2*LIMB_W)'(x_in[I*LIMB_W +: LIMB_W]) *
                   (2*LIMB_W)'(y_in[J*LIMB_W +: LIMB_W]);
  assign acc_nxt = acc_in + (PP_W'(pp) << (LIMB_W * (I + J)));

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_in;
      y_r    <= y_in;
      acc_r  <= acc_nxt;
      side_r <= side_in;
    end
  end

  assign x_out    = x_r;
  assign y_out    = y_r;
  assign acc_out  = acc_r;
  assign side_out = side_r;

endmodule

@@ sv/rsi_sqrt_cell.sv @@
module rsi_sqrt_cell import rsi_pkg::*; #(
  parameter int QW = 67,
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [2*QW-1:0]   rad_in,
  input  logic [QW:0]       rem_in,
  input  logic [QW-1:0]     root_in,
  input  logic [SW-1:0]     side_in,
  output logic [2*QW-1:0]   rad_out,
  output logic [QW:0]       rem_out,
  output logic [QW-1:0]     root_out,
  output logic [SW-1:0]     side_out
);

  logic [QW+2:0]   rt, trial;
  logic            ge;
  logic [QW:0]     rem_nxt;
  logic [2*QW-1:0] rad_r;
  logic [QW:0]     rem_r;
  logic [QW-1:0]   root_r;
  logic [SW-1:0]   side_r;

  assign rt      = {rem_in, rad_in[2*QW-1 -: 2]};
  assign trial   = (QW+3)'({root_in, 2'b01});
  assign ge      = rt >= trial;
  assign rem_nxt = ge ? (QW+1)'(rt - trial) : (QW+1)'(rt);

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {rad_in[2*QW-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {root_in[QW-2:0], ge};
      side_r <= side_in;
    end
  end

  assign rad_out  = rad_r;
  assign rem_out  = rem_r;
  assign root_out = root_r;
  assign side_out = side_r;

endmodule

@@ sv/rsi_div_cell.sv @@
module rsi_div_cell import rsi_pkg::*; #(
  parameter int DNW = 65,
  parameter int QW  = 32,
  parameter int SW  = 1
) (
  input  logic           clk,
  input  logic           en,
  input  logic [DNW-1:0] rem_in,
  input  logic [DNW-1:0] den_in,
  input  logic [QW-1:0]  num_in,
  input  logic [QW-1:0]  quo_in,
  input  logic [SW-1:0]  side_in,
  output logic [DNW-1:0] rem_out,
  output logic [DNW-1:0] den_out,
  output logic [QW-1:0]  num_out,
  output logic [QW-1:0]  quo_out,
  output logic [SW-1:0]  side_out
);

  logic [DNW:0]   rt;
  logic           ge;
  logic [DNW-1:0] rem_nxt;
  logic [DNW-1:0] rem_r, den_r;
  logic [QW-1:0]  num_r, quo_r;
  logic [SW-1:0]  side_r;

  assign rt      = {rem_in, num_in[QW-1]};
  assign ge      = rt >= {1'b0, den_in};
  assign rem_nxt = ge ? DNW'(rt - {1'b0, den_in}) : DNW'(rt);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      den_r  <= den_in;
      num_r  <= {num_in[QW-2:0], 1'b0};
      quo_r  <= {quo_in[QW-2:0], ge};
      side_r <= side_in;
    end
  end

  assign rem_out  = rem_r;
  assign den_out  = den_r;
  assign num_out  = num_r;
  assign quo_out  = quo_r;
  assign side_out = side_r;

endmodule

@@ sv/ray_sphere_intersection.sv @@
// 117 pipeline stages from request to result, plus the output register.
// Throughput: one request per cycle; the row of 67 root cells and 32 divide cells is fully
// pipelined, and a request enters while a finished result waits unless the last stage is full.
// Reset (rst_n, synchronous): clears all valid bits and sets the center to zero and the
// radius to 1.0; no clearing pass.
module ray_sphere_intersection import rsi_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_req_t               in_req,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_res_t              out_res
);

  localparam int NCELL = MAC_NL * MAC_NL;
  localparam int NW    = TMAG_W + FRAC_BITS;
  localparam int LAT   = 4 + NCELL + 1 + ROOT_W + 3 + QUO_W + 1;
  localparam int MSW   = $bits(mac_side_t);
  localparam int SSW   = $bits(sq_side_t);
  localparam int DSW   = $bits(div_flags_t);

  logic signed [31:0] cx_r, cy_r, cz_r;
  logic [30:0]        rad_r;
  logic [61:0]        rr_r;

  logic               en;
  logic [LAT-1:0]     v_r;

  logic signed [31:0] d_r  [0:2];
  logic signed [32:0] w_r  [0:2];
  logic signed [63:0] dd_r [0:2];
  logic signed [64:0] dw_r [0:2];
  logic signed [65:0] ww_r [0:2];

  logic [A_W-1:0]        a_nxt, a3_r, a4_r;
  logic signed [B_W-1:0] b_nxt, b3_r, b4_r;
  logic signed [C_W-1:0] c_nxt, c3_r;
  logic                  dg3_r, dg4_r, cneg4_r;
  logic [MAG_W-1:0]      bm_r, cm_r;

  logic [OP_W-1:0] m1x [0:NCELL];
  logic [OP_W-1:0] m1y [0:NCELL];
  logic [PP_W-1:0] m1a [0:NCELL];
  logic [MSW-1:0]  m1s [0:NCELL];
  logic [OP_W-1:0] m2x [0:NCELL];
  logic [OP_W-1:0] m2y [0:NCELL];
  logic [PP_W-1:0] m2a [0:NCELL];
  logic [0:0]      m2s [0:NCELL];

  mac_side_t        ms_in, ms_out;
  logic [DL_W-1:0]  bb, ac4, delta_nxt, delta5_r;
  mac_side_t        ms5_r;
  sq_side_t         sq_in, sq_out;

  logic [DL_W-1:0]   sr_rad  [0:ROOT_W];
  logic [ROOT_W:0]   sr_rem  [0:ROOT_W];
  logic [ROOT_W-1:0] sr_root [0:ROOT_W];
  logic [SSW-1:0]    sr_side [0:ROOT_W];

  logic signed [T_W-1:0] t6_r;
  logic [A_W-1:0]        a6_r, a7_r;
  logic                  dn6_r, dg6_r, dn7_r, dg7_r, nneg7_r;
  logic [TMAG_W-1:0]     nmag7_r;
  logic [NW-1:0]         nfull;
  logic [NW-QUO_W-1:0]   nh;
  logic [DEN_W-1:0]      den8;
  logic                  ovf_nxt;
  div_flags_t            df_in, df_out;
  logic [DEN_W-1:0]      r8_r, den8_r;
  logic [QUO_W-1:0]      lo8_r;
  div_flags_t            df8_r;

  logic [DEN_W-1:0] dv_rem  [0:QUO_W];
  logic [DEN_W-1:0] dv_den  [0:QUO_W];
  logic [QUO_W-1:0] dv_num  [0:QUO_W];
  logic [QUO_W-1:0] dv_quo  [0:QUO_W];
  logic [DSW-1:0]   dv_side [0:QUO_W];

  logic [QUO_W:0]   mag;
  logic             hit_nxt;
  logic [QUO_W-1:0] dist_nxt;
  out_res_t         fin_r, res_r;
  logic             out_valid_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      cz_r  <= '0;
      rad_r <= 31'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CENTER_X: cx_r  <= cfg_wdata;
        CFG_CENTER_Y: cy_r  <= cfg_wdata;
        CFG_CENTER_Z: cz_r  <= cfg_wdata;
        CFG_RADIUS:   rad_r <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rr_r <= 62'(rad_r) * 62'(rad_r);
  end

  // flow control
  assign en       = !(v_r[LAT-1] && out_valid_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  // dot products
  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= in_req.dir_x;
      d_r[1] <= in_req.dir_y;
      d_r[2] <= in_req.dir_z;
      w_r[0] <= $signed({in_req.origin_x[31], in_req.origin_x}) - $signed({cx_r[31], cx_r});
      w_r[1] <= $signed({in_req.origin_y[31], in_req.origin_y}) - $signed({cy_r[31], cy_r});
      w_r[2] <= $signed({in_req.origin_z[31], in_req.origin_z}) - $signed({cz_r[31], cz_r});
      for (int i = 0; i < 3; i++) begin
        dd_r[i] <= 64'(d_r[i]) * 64'(d_r[i]);
        dw_r[i] <= 65'(d_r[i]) * 65'(w_r[i]);
        ww_r[i] <= 66'(w_r[i]) * 66'(w_r[i]);
      end
    end
  end

  assign a_nxt = dd_r[0][A_W-1:0] + dd_r[1][A_W-1:0] + dd_r[2][A_W-1:0];
  assign b_nxt = (B_W'(dw_r[0]) + B_W'(dw_r[1]) + B_W'(dw_r[2])) <<< 1;
  assign c_nxt = C_W'(ww_r[0]) + C_W'(ww_r[1]) + C_W'(ww_r[2]) - $signed({5'b0, rr_r});

  always_ff @(posedge clk) begin
    if (en) begin
      a3_r    <= a_nxt;
      b3_r    <= b_nxt;
      c3_r    <= c_nxt;
      dg3_r   <= (a_nxt == '0);
      a4_r    <= a3_r;
      b4_r    <= b3_r;
      dg4_r   <= dg3_r;
      cneg4_r <= c3_r[C_W-1];
      bm_r    <= b3_r[B_W-1] ? MAG_W'(-b3_r) : b3_r[MAG_W-1:0];
      cm_r    <= c3_r[C_W-1] ? MAG_W'(-c3_r) : c3_r[MAG_W-1:0];
    end
  end

  // b*b and a*|c| as rows of limb multiply-accumulate cells
  assign ms_in = '{b: b4_r, a: a4_r, degen: dg4_r};
  assign m1x[0] = OP_W'(bm_r);
  assign m1y[0] = OP_W'(bm_r);
  assign m1a[0] = '0;
  assign m1s[0] = ms_in;
  assign m2x[0] = OP_W'(a4_r);
  assign m2y[0] = OP_W'(cm_r);
  assign m2a[0] = '0;
  assign m2s[0] = cneg4_r;

  for (genvar k = 0; k < NCELL; k++) begin : g_mac
    localparam int LI = k / MAC_NL;
    localparam int LJ = k % MAC_NL;
    rsi_mac_cell #(.I(LI), .J(LJ), .SW(MSW)) u_bb (
      .clk(clk), .en(en),
      .x_in(m1x[k]), .y_in(m1y[k]), .acc_in(m1a[k]), .side_in(m1s[k]),
      .x_out(m1x[k+1]), .y_out(m1y[k+1]), .acc_out(m1a[k+1]), .side_out(m1s[k+1])
    );
    rsi_mac_cell #(.I(LI), .J(LJ), .SW(1)) u_ac (
      .clk(clk), .en(en),
      .x_in(m2x[k]), .y_in(m2y[k]), .acc_in(m2a[k]), .side_in(m2s[k]),
      .x_out(m2x[k+1]), .y_out(m2y[k+1]), .acc_out(m2a[k+1]), .side_out(m2s[k+1])
    );
  end

  // discriminant
  assign ms_out    = m1s[NCELL];
  assign bb        = m1a[NCELL][DL_W-1:0];
  assign ac4       = m2a[NCELL][DL_W-1:0] << 2;
  assign delta_nxt = m2s[NCELL][0] ? bb + ac4 : bb - ac4;

  always_ff @(posedge clk) begin
    if (en) begin
      delta5_r <= delta_nxt;
      ms5_r    <= ms_out;
    end
  end

  // floor square root, two radicand bits per cell
  assign sq_in = '{b: ms5_r.b, a: ms5_r.a, dneg: delta5_r[DL_W-1], degen: ms5_r.degen};
  assign sr_rad[0]  = delta5_r;
  assign sr_rem[0]  = '0;
  assign sr_root[0] = '0;
  assign sr_side[0] = sq_in;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    rsi_sqrt_cell #(.QW(ROOT_W), .SW(SSW)) u_cell (
      .clk(clk), .en(en),
      .rad_in(sr_rad[k]), .rem_in(sr_rem[k]), .root_in(sr_root[k]), .side_in(sr_side[k]),
      .rad_out(sr_rad[k+1]), .rem_out(sr_rem[k+1]), .root_out(sr_root[k+1]),
      .side_out(sr_side[k+1])
    );
  end

  assign sq_out = sr_side[ROOT_W];

  // numerator -b - s, magnitude, overflow check
  assign nfull   = {nmag7_r, FRAC_BITS'(0)};
  assign nh      = nfull[NW-1:QUO_W];
  assign den8    = {a7_r, 1'b0};
  assign ovf_nxt = DEN_W'(nh) >= den8;
  assign df_in   = '{ovf: ovf_nxt, nneg: nneg7_r, dneg: dn7_r, degen: dg7_r};

  always_ff @(posedge clk) begin
    if (en) begin
      t6_r    <= -T_W'(sq_out.b) - $signed({2'b0, sr_root[ROOT_W]});
      a6_r    <= sq_out.a;
      dn6_r   <= sq_out.dneg;
      dg6_r   <= sq_out.degen;
      nmag7_r <= t6_r[T_W-1] ? TMAG_W'(-t6_r) : t6_r[TMAG_W-1:0];
      nneg7_r <= t6_r[T_W-1];
      a7_r    <= a6_r;
      dn7_r   <= dn6_r;
      dg7_r   <= dg6_r;
      r8_r    <= ovf_nxt ? '0 : DEN_W'(nh);
      den8_r  <= den8;
      lo8_r   <= nfull[QUO_W-1:0];
      df8_r   <= df_in;
    end
  end

  // restoring division, one quotient bit per cell
  assign dv_rem[0]  = r8_r;
  assign dv_den[0]  = den8_r;
  assign dv_num[0]  = lo8_r;
  assign dv_quo[0]  = '0;
  assign dv_side[0] = df8_r;

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    rsi_div_cell #(.DNW(DEN_W), .QW(QUO_W), .SW(DSW)) u_cell (
      .clk(clk), .en(en),
      .rem_in(dv_rem[k]), .den_in(dv_den[k]), .num_in(dv_num[k]), .quo_in(dv_quo[k]),
      .side_in(dv_side[k]),
      .rem_out(dv_rem[k+1]), .den_out(dv_den[k+1]), .num_out(dv_num[k+1]),
      .quo_out(dv_quo[k+1]), .side_out(dv_side[k+1])
    );
  end

  // floor, sign and saturation
  assign df_out  = dv_side[QUO_W];
  assign mag     = {1'b0, dv_quo[QUO_W]} + (QUO_W+1)'(|dv_rem[QUO_W]);
  assign hit_nxt = !df_out.degen && !df_out.dneg;

  always_comb begin
    if (!hit_nxt) begin
      dist_nxt = '0;
    end else if (df_out.nneg) begin
      dist_nxt = (df_out.ovf || mag > (QUO_W+1)'(DIST_MIN)) ? DIST_MIN : QUO_W'(-mag);
    end else begin
      dist_nxt = (df_out.ovf || dv_quo[QUO_W][QUO_W-1]) ? DIST_MAX : dv_quo[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= '{hit: hit_nxt, distance: dist_nxt, degenerate: df_out.degen};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= v_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      res_r <= fin_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_res.hit && out_res.degenerate))
    else $error("hit and degenerate both set");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.hit |-> out_res.distance == '0)
    else $error("miss with nonzero distance");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v_r[LAT-1] && out_valid_r && out_stall)
    else $error("input stalled without a blocked result");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && !v_r[LAT-1] |=> !out_valid_r)
    else $error("result appeared from an empty last stage");

endmodule

@@ bench/ray_sphere_intersection_test.sv @@
module ray_sphere_intersection_test import rsi_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int DRAIN_CYCLES = 140;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 4'd9;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_res_t out_res;

  ray_sphere_intersection dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_res(out_res)
  );

  always #4 clk = ~clk;

  logic signed [31:0] sphere_cx = 0, sphere_cy = 0, sphere_cz = 0;
  logic [30:0] sphere_r = 31'd65536;

  in_req_t  ray_queue[$];
  out_res_t hit_queue[$];
  int errors = 0;
  int in_gap = 0, out_gap = 0;
  bit in_burst = 0, out_burst = 0;
  longint cycles = 0;

  function automatic out_res_t trace_ray(in_req_t r);
    logic signed [255:0] dx, dy, dz, wx, wy, wz, rsq, a, b, c, delta, s, cand;
    logic signed [255:0] num, den, q, lo, hi;
    out_res_t res;
    dx = 256'(r.dir_x); dy = 256'(r.dir_y); dz = 256'(r.dir_z);
    wx = 256'(r.origin_x); wy = 256'(r.origin_y); wz = 256'(r.origin_z);
    wx = wx - 256'(sphere_cx); wy = wy - 256'(sphere_cy); wz = wz - 256'(sphere_cz);
    rsq = {225'b0, sphere_r};
    a = dx * dx + dy * dy + dz * dz;
    b = 2 * (dx * wx + dy * wy + dz * wz);
    c = wx * wx + wy * wy + wz * wz - rsq * rsq;
    res = '0;
    if (a == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    delta = b * b - 4 * a * c;
    if (delta < 0) return res;
    s = 0;
    for (int i = 90; i >= 0; i--) begin
      cand = s | (256'sd1 <<< i);
      if (cand * cand <= delta) s = cand;
    end
    num = (-b - s) <<< FRAC;
    den = 2 * a;
    q = num / den;
    if (num < 0 && (num % den) != 0) q = q - 1;
    lo = -256'sd2147483648;
    hi = 256'sd2147483647;
    res.hit = 1'b1;
    if (q < lo) res.distance = DIST_MIN;
    else if (q > hi) res.distance = DIST_MAX;
    else res.distance = q[31:0];
    return res;
  endfunction

  function automatic int draw_gap(bit burst);
    return burst ? $urandom_range(0, 19) : 0;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) hit_queue.push_back(trace_ray(in_req));
      if ($urandom_range(0, 63) == 0) in_burst = ~in_burst;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (ray_queue.size() > 0) begin
        in_req <= ray_queue.pop_front();
        in_valid <= 1'b1;
        in_gap = draw_gap(in_burst);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (hit_queue.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_res);
          errors++;
        end else begin
          out_res_t e;
          e = hit_queue.pop_front();
          if (out_res.hit !== e.hit) begin
            $display("%0t: hit expected %0d actual %0d", $time, e.hit, out_res.hit);
            errors++;
          end
          if (out_res.distance !== e.distance) begin
            $display("%0t: distance expected %0d actual %0d", $time, e.distance,
                     out_res.distance);
            errors++;
          end
          if (out_res.degenerate !== e.degenerate) begin
            $display("%0t: degenerate expected %0d actual %0d", $time, e.degenerate,
                     out_res.degenerate);
            errors++;
          end
        end
      end
      if ($urandom_range(0, 63) == 0) out_burst = ~out_burst;
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_gap = draw_gap(out_burst);
        out_stall <= (out_gap > 0);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ray_sphere_intersection_test failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CENTER_X: sphere_cx = val;
      CFG_CENTER_Y: sphere_cy = val;
      CFG_CENTER_Z: sphere_cz = val;
      CFG_RADIUS:   sphere_r = val[30:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (ray_queue.size() > 0 || in_valid || hit_queue.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_ray(int dx, int dy, int dz, int ox, int oy, int oz);
    in_req_t r;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    ray_queue.push_back(r);
  endtask

  function automatic logic [31:0] near_value(logic [31:0] base);
    return base + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
  endfunction

  function automatic logic [31:0] any_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
    endcase
  endfunction

  // mostly rays aimed at the sphere, the rest anywhere
  task automatic random_rays(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) != 0) begin
        in_req_t r;
        r.origin_x = near_value(sphere_cx - (5 << FRAC));
        r.origin_y = near_value(sphere_cy);
        r.origin_z = near_value(sphere_cz);
        r.dir_x = $urandom_range(1, 1 << 18);
        r.dir_y = $signed($urandom_range(0, 1 << 16)) - (1 << 15);
        r.dir_z = $signed($urandom_range(0, 1 << 16)) - (1 << 15);
        if ($urandom_range(0, 1)) r.dir_y = $urandom_range(0, 3) - 1;
        ray_queue.push_back(r);
      end else begin
        add_ray(any_coord(), any_coord(), any_coord(), any_coord(), any_coord(), any_coord());
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_ray(0, 0, 0, 0, 0, 0);
    add_ray(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 5);
    add_ray(1 << FRAC, 0, 0, 0, 1 << FRAC, 0);
    add_ray(1 << FRAC, 0, 0, 0, 2 << FRAC, 0);
    add_ray(1 << FRAC, 0, 0, -(4 << FRAC), 0, 0);
    add_ray(1 << FRAC, 0, 0, 0, 0, 0);
    add_ray(-(1 << FRAC), 0, 0, -(4 << FRAC), 0, 0);
    add_ray(1, 0, 0, -(3 << FRAC), 0, 0);
    add_ray(0, 0, 1, 0, 0, 32'h8000_0000);
    add_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF);
    add_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000);
    add_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
    add_ray(0, 1 << FRAC, 0, 0, -(2 << FRAC), 0);
    add_ray(0, 0, 1 << FRAC, 0, 0, 100 << FRAC);
    random_rays(200);
    drain();

    write_reg(CFG_CENTER_X, 32'h8000_0000);
    write_reg(CFG_CENTER_Y, 32'h7FFF_FFFF);
    write_reg(CFG_CENTER_Z, 32'h8000_0000);
    write_reg(CFG_RADIUS, 32'h7FFF_FFFF);
    add_ray(1 << FRAC, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    add_ray(0, 0, 0, 0, 0, 0);
    random_rays(200);
    drain();

    write_reg(CFG_RADIUS, 0);
    write_reg(CFG_CENTER_X, 0);
    write_reg(CFG_CENTER_Y, 0);
    write_reg(CFG_CENTER_Z, 0);
    add_ray(1 << FRAC, 0, 0, -(2 << FRAC), 0, 0);
    add_ray(1 << FRAC, 0, 0, 0, 0, 0);
    random_rays(200);
    drain();

    write_reg(CFG_UNUSED, 32'h1234_5678);
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_CENTER_X, any_coord());
      write_reg(CFG_CENTER_Y, any_coord());
      write_reg(CFG_CENTER_Z, any_coord());
      write_reg(CFG_RADIUS, $urandom_range(1 << 14, 8 << FRAC));
      random_rays(200);
      drain();
    end

    if (errors == 0) begin
      $display("ray_sphere_intersection_test passed");
    end else begin
      $display("ray_sphere_intersection_test failed");
    end
    $finish;
  end

endmodule

@@ ray_sphere_intersection.f @@
sv/rsi_pkg.sv
sv/rsi_mac_cell.sv
sv/rsi_sqrt_cell.sv
sv/rsi_div_cell.sv
sv/ray_sphere_intersection.sv
bench/ray_sphere_intersection_test.sv
